// ===== rtl/core/length_prefixed_fragment_reassembly_assert.svh =====
// Assertion macros for the checker of the fragment reassembly block.
// No dependencies; included by the port checker.
`ifndef LENGTH_PREFIXED_FRAGMENT_REASSEMBLY_ASSERT_SVH
`define LENGTH_PREFIXED_FRAGMENT_REASSEMBLY_ASSERT_SVH

// same-cycle implication under reset
`define LPFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lpfr assertion failed");

// next-cycle implication under reset
`define LPFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lpfr assertion failed");

`endif

// ===== rtl/core/lpfr_pkg.sv =====
// Shared types, codes and sizes for the length-prefixed fragment reassembly block.
// No dependencies.
`default_nettype none

package lpfr_pkg;

    localparam int BUF_BYTES = 16384;
    localparam int BUF_AW    = $clog2(BUF_BYTES);
    localparam int FILL_W    = 15;

    localparam logic [31:0] BUF_BYTES_W       = 32'(BUF_BYTES);
    localparam logic [11:0] HDR_BYTES         = 12'd4;
    localparam logic [11:0] MIN_FIRST_BYTES   = 12'd6;
    localparam logic [23:0] TOTAL_LIMIT_RESET = 24'd10485760;

    // opcodes
    localparam logic [1:0] OP_FRAG  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_FIRST_OK  = 3'd0;
    localparam logic [2:0] ST_APPENDED  = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;
    localparam logic [2:0] ST_READ      = 3'd6;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        data_byte;
        logic              frag_first;
        logic              frag_last;
        logic [11:0]       frag_length;
        logic [BUF_AW-1:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } t_mem_cmd;

    typedef struct packed {
        logic              vld;
        logic [2:0]        status;
        logic [FILL_W-1:0] fill;
        logic [31:0]       total;
        logic              is_read;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/lpfr_buf_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module lpfr_buf_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpfr_ctrl.sv =====
// Fragment state tracking: header capture, length checks, buffer write/read commands.
// Depends on lpfr_pkg.
`default_nettype none

module lpfr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire lpfr_pkg::t_in_item i_item,
    input  wire logic [23:0]        i_max_total,
    output lpfr_pkg::t_mem_cmd      o_cmd,
    output lpfr_pkg::t_result       o_res
);

    logic [lpfr_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [31:0] r_total, n_total;
    logic [31:0] r_hs, n_hs;
    logic [11:0] r_off, n_off;
    logic [11:0] r_len, n_len;
    logic        r_isf, n_isf;
    logic        r_rej, n_rej;

    // state as seen after a fragment start restarts it
    logic [11:0] e_off, e_len;
    logic [31:0] e_hs;
    logic        e_isf, e_rej;
    logic        hdr_rej;
    logic [2:0]  hdr_status;
    logic [31:0] wsum;
    logic [31:0] append_end;

    always_comb begin
        n_fill = r_fill;
        n_total = r_total;
        n_hs = r_hs;
        n_off = r_off;
        n_len = r_len;
        n_isf = r_isf;
        n_rej = r_rej;
        o_cmd = '0;
        o_res = '0;
        e_off = r_off;
        e_len = r_len;
        e_hs = r_hs;
        e_isf = r_isf;
        e_rej = r_rej;
        hdr_rej = 1'b0;
        hdr_status = lpfr_pkg::ST_TOO_LARGE;
        wsum = '0;
        append_end = {17'd0, r_fill} + {20'd0, i_item.frag_length};
        o_cmd.wdata = i_item.data_byte;
        o_cmd.raddr = i_item.read_address;

        if (i_fire) begin
            case (i_item.op)
                lpfr_pkg::OP_CLEAR: begin
                    n_fill = '0;
                    n_total = '0;
                    n_hs = '0;
                    n_off = '0;
                    n_len = '0;
                    n_isf = 1'b0;
                    n_rej = 1'b0;
                    o_res.vld = 1'b1;
                    o_res.status = lpfr_pkg::ST_CLEARED;
                end
                lpfr_pkg::OP_READ: begin
                    o_cmd.re = 1'b1;
                    o_res.vld = 1'b1;
                    o_res.status = lpfr_pkg::ST_READ;
                    o_res.is_read = 1'b1;
                end
                lpfr_pkg::OP_FRAG: begin
                    if (i_item.frag_first) begin
                        e_len = i_item.frag_length;
                        e_off = '0;
                        e_hs = '0;
                        e_rej = 1'b0;
                        e_isf = (r_fill == '0);
                    end
                    n_len = e_len;
                    n_off = e_off;
                    n_hs = e_hs;
                    n_isf = e_isf;
                    n_rej = e_rej;

                    if (i_item.frag_first && e_isf &&
                        (i_item.frag_length < lpfr_pkg::MIN_FIRST_BYTES)) begin
                        n_rej = 1'b1;
                        if (i_item.frag_last) begin
                            n_len = '0;
                        end
                        o_res.vld = 1'b1;
                        o_res.status = lpfr_pkg::ST_TOO_SHORT;
                    end else if (i_item.frag_first && !e_isf &&
                                 (append_end > lpfr_pkg::BUF_BYTES_W)) begin
                        n_rej = 1'b1;
                        if (i_item.frag_last) begin
                            n_len = '0;
                        end
                        o_res.vld = 1'b1;
                        o_res.status = lpfr_pkg::ST_OVERFLOW;
                    end else if (!i_item.frag_first && r_len == '0) begin
                        // orphan byte, no fragment open
                    end else if (e_rej) begin
                        if (i_item.frag_last) begin
                            n_len = '0;
                        end
                    end else begin
                        if (e_off < e_len) begin
                            n_off = e_off + 12'd1;
                            if (e_isf) begin
                                if (e_off < lpfr_pkg::HDR_BYTES) begin
                                    n_hs = {e_hs[23:0], i_item.data_byte};
                                    if (e_off == lpfr_pkg::HDR_BYTES - 12'd1) begin
                                        if (n_hs > {8'd0, i_max_total} ||
                                            n_hs > lpfr_pkg::BUF_BYTES_W) begin
                                            hdr_rej = 1'b1;
                                        end else if ({20'd0, e_len} - 32'd4 >
                                                     lpfr_pkg::BUF_BYTES_W) begin
                                            hdr_rej = 1'b1;
                                            hdr_status = lpfr_pkg::ST_OVERFLOW;
                                        end
                                    end
                                end else begin
                                    wsum = {17'd0, r_fill} + {20'd0, e_off} -
                                           {20'd0, lpfr_pkg::HDR_BYTES};
                                    o_cmd.we = (wsum < lpfr_pkg::BUF_BYTES_W);
                                end
                            end else begin
                                wsum = {17'd0, r_fill} + {20'd0, e_off};
                                o_cmd.we = (wsum < lpfr_pkg::BUF_BYTES_W);
                            end
                        end
                        o_cmd.waddr = wsum[lpfr_pkg::BUF_AW-1:0];

                        if (hdr_rej) begin
                            n_rej = 1'b1;
                            if (i_item.frag_last) begin
                                n_len = '0;
                            end
                            o_res.vld = 1'b1;
                            o_res.status = hdr_status;
                        end else if (i_item.frag_last) begin
                            n_len = '0;
                            o_res.vld = 1'b1;
                            if (e_isf) begin
                                if (n_off < lpfr_pkg::MIN_FIRST_BYTES) begin
                                    n_rej = 1'b1;
                                    o_res.status = lpfr_pkg::ST_TOO_SHORT;
                                end else begin
                                    n_fill = {3'd0, n_off - lpfr_pkg::HDR_BYTES};
                                    n_total = n_hs;
                                    o_res.status = lpfr_pkg::ST_FIRST_OK;
                                end
                            end else begin
                                n_fill = r_fill + {3'd0, n_off};
                                o_res.status = lpfr_pkg::ST_APPENDED;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        o_res.fill = n_fill;
        o_res.total = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_total <= '0;
            r_hs <= '0;
            r_off <= '0;
            r_len <= '0;
            r_isf <= 1'b0;
            r_rej <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_total <= n_total;
            r_hs <= n_hs;
            r_off <= n_off;
            r_len <= n_len;
            r_isf <= n_isf;
            r_rej <= n_rej;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_fragment_reassembly.sv =====
// Top level of the length-prefixed fragment reassembly block.
// Depends on lpfr_pkg, lpfr_ctrl and lpfr_buf_ram.
`default_nettype none

// Accepts one transaction per clock while s_axis_tready is high and returns at most one
// result for it, which passes through the result stage and the output register before
// it is presented on the output. Each transaction makes at most one access
// to the 16384 x 8 reassembly RAM (one byte write for a fragment byte, one read for a
// buffer read), issued in the accept cycle; the RAM registers the read data beside the
// result stage. Since every access is issued in the same stage, a read that follows a
// write to the same byte in the next cycle sees the new data. The RAM is not cleared at
// reset; reading a byte that was never written returns an undefined value. A result stage
// and an output register let input be taken while a result waits on the output.
module length_prefixed_fragment_reassembly (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // data_byte, frag_length, read_address, zero pad
    input  wire logic        s_axis_tlast,  // frag_last
    input  wire logic [2:0]  s_axis_tuser,  // op, frag_first
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // fill_count, total_length, read_data, zero pad
    output logic [2:0]       m_axis_tuser,  // status
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [23:0] i_cfg_data     // max_total_length
);

    lpfr_pkg::t_in_item item;
    lpfr_pkg::t_mem_cmd cmd;
    lpfr_pkg::t_result  res;

    logic        fire;
    logic        s1_go;
    logic [7:0]  rdata;
    logic [23:0] r_max_total;

    logic              r_s1_vld;
    lpfr_pkg::t_result r_s1_res;

    logic                        r_out_vld;
    logic [2:0]                  r_out_status;
    logic [lpfr_pkg::FILL_W-1:0] r_out_fill;
    logic [31:0]                 r_out_total;
    logic [7:0]                  r_out_rdata;

    assign item.op = s_axis_tuser[1:0];
    assign item.frag_first = s_axis_tuser[2];
    assign item.frag_last = s_axis_tlast;
    assign item.data_byte = s_axis_tdata[7:0];
    assign item.frag_length = s_axis_tdata[19:8];
    assign item.read_address = s_axis_tdata[33:20];

    assign s1_go = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || s1_go;
    assign fire = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_total <= lpfr_pkg::TOTAL_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_max_total <= i_cfg_data;
        end
    end

    lpfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (item),
        .i_max_total (r_max_total),
        .o_cmd       (cmd),
        .o_res       (res)
    );

    lpfr_buf_ram #(
        .DEPTH (lpfr_pkg::BUF_BYTES),
        .WIDTH (8)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (cmd.we),
        .i_waddr (cmd.waddr),
        .i_wdata (cmd.wdata),
        .i_re    (cmd.re),
        .i_raddr (cmd.raddr),
        .o_rdata (rdata)
    );

    // result stage: waits here for the RAM read data; holds while output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= fire && res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_s1_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_vld) begin
            r_out_status <= r_s1_res.status;
            r_out_fill <= r_s1_res.fill;
            r_out_total <= r_s1_res.total;
            r_out_rdata <= r_s1_res.is_read ? rdata : 8'd0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser = r_out_status;
    assign m_axis_tdata = {1'b0, r_out_rdata, r_out_total, r_out_fill};

endmodule

`default_nettype wire

// ===== rtl/core/lpfr_port_chk.sv =====
// Port-level checker for the fragment reassembly top level, bound to it below.
// Depends on lpfr_pkg and length_prefixed_fragment_reassembly_assert.svh.
`default_nettype none

`include "length_prefixed_fragment_reassembly_assert.svh"

module lpfr_port_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    logic out_fire;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // a clear reports an empty buffer and no announced total
    `LPFR_ASSERT_SAME(a_clear_zero, i_clk, i_rst_n,
        out_fire && m_axis_tuser == lpfr_pkg::ST_CLEARED,
        m_axis_tdata[46:0] == 47'd0)

    // only a read result carries read data
    `LPFR_ASSERT_SAME(a_rdata_only_read, i_clk, i_rst_n,
        out_fire && m_axis_tuser != lpfr_pkg::ST_READ,
        m_axis_tdata[54:47] == 8'd0)

    // an accepted first fragment fits the buffer and has at least two data bytes
    `LPFR_ASSERT_SAME(a_first_ok_bounds, i_clk, i_rst_n,
        out_fire && m_axis_tuser == lpfr_pkg::ST_FIRST_OK,
        m_axis_tdata[46:15] <= lpfr_pkg::BUF_BYTES_W && m_axis_tdata[14:0] >= 15'd2)

    `LPFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind length_prefixed_fragment_reassembly lpfr_port_chk u_lpfr_port_chk (.*);

`default_nettype wire

// ===== tb/length_prefixed_fragment_reassembly_tb.sv =====
// Self-checking testbench for length_prefixed_fragment_reassembly: stream driver and monitor,
// a reassembly predictor checked result by result, and phases with different total limits.
// Depends on lpfr_pkg and the block's RTL.
`timescale 1ns / 100ps

module length_prefixed_fragment_reassembly_tb;
    import lpfr_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, block ignores it

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] fill;
        logic [31:0] total;
        logic [7:0]  rdata;
    } t_frag_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // data_byte, frag_length, read_address, zero pad
    logic        s_axis_tlast = 1'b0; // frag_last
    logic [2:0]  s_axis_tuser = '0;  // op, frag_first
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [55:0] m_axis_tdata;       // fill_count, total_length, read_data, zero pad
    wire  [2:0]  m_axis_tuser;       // status
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [23:0] i_cfg_data = '0;    // max_total_length

    length_prefixed_fragment_reassembly DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- reassembly predictor ----------------
    logic [7:0]  ra_mem [BUF_BYTES];
    bit          ra_written [BUF_BYTES];
    int unsigned ra_fill = 0;
    logic [31:0] ra_total = '0;
    logic [31:0] ra_hdr = '0;
    int unsigned ra_off = 0;
    int unsigned ra_flen = 0;   // 0: no fragment open
    bit          ra_is_first = 1'b0;
    bit          ra_rejected = 1'b0;
    logic [23:0] ra_limit = TOTAL_LIMIT_RESET;

    function automatic t_frag_res make_result(input logic [2:0] st, input logic [7:0] rd);
        t_frag_res r;
        r.status = st;
        r.fill   = ra_fill[14:0];
        r.total  = ra_total;
        r.rdata  = rd;
        return r;
    endfunction

    function automatic t_frag_res refuse_frag(input logic [2:0] st, input bit last);
        ra_rejected = 1'b1;
        if (last)
            ra_flen = 0;
        return make_result(st, 8'h00);
    endfunction

    function automatic void keep_byte(input int unsigned a, input logic [7:0] b);
        if (a < BUF_BYTES) begin
            ra_mem[a]     = b;
            ra_written[a] = 1'b1;
        end
    endfunction

    // returns 1 when the transaction produces a result
    function automatic bit reassemble_step(input t_in_item it, output t_frag_res r);
        int unsigned idx;
        if (it.op == OP_CLEAR) begin
            ra_fill     = 0;
            ra_total    = '0;
            ra_hdr      = '0;
            ra_off      = 0;
            ra_flen     = 0;
            ra_is_first = 1'b0;
            ra_rejected = 1'b0;
            r = make_result(ST_CLEARED, 8'h00);
            return 1'b1;
        end
        if (it.op == OP_READ) begin
            r = make_result(ST_READ, ra_mem[it.read_address]);
            return 1'b1;
        end
        if (it.op == OP_NONE)
            return 1'b0;

        if (it.frag_first) begin
            ra_flen     = it.frag_length;
            ra_off      = 0;
            ra_hdr      = '0;
            ra_rejected = 1'b0;
            ra_is_first = (ra_fill == 0);
            if (ra_is_first && it.frag_length < MIN_FIRST_BYTES) begin
                r = refuse_frag(ST_TOO_SHORT, it.frag_last);
                return 1'b1;
            end
            if (!ra_is_first && ra_fill + it.frag_length > BUF_BYTES) begin
                r = refuse_frag(ST_OVERFLOW, it.frag_last);
                return 1'b1;
            end
        end else if (ra_flen == 0) begin
            return 1'b0;
        end

        if (ra_rejected) begin
            if (it.frag_last)
                ra_flen = 0;
            return 1'b0;
        end

        idx = ra_off;
        if (idx < ra_flen) begin
            ra_off = idx + 1;
            if (ra_is_first) begin
                if (idx < HDR_BYTES) begin
                    ra_hdr = {ra_hdr[23:0], it.data_byte};
                    if (idx == HDR_BYTES - 1) begin
                        if (ra_hdr > ra_limit || ra_hdr > BUF_BYTES) begin
                            r = refuse_frag(ST_TOO_LARGE, it.frag_last);
                            return 1'b1;
                        end
                        if (ra_flen - HDR_BYTES > BUF_BYTES) begin
                            r = refuse_frag(ST_OVERFLOW, it.frag_last);
                            return 1'b1;
                        end
                    end
                end else begin
                    keep_byte(ra_fill + idx - HDR_BYTES, it.data_byte);
                end
            end else begin
                keep_byte(ra_fill + idx, it.data_byte);
            end
        end

        if (!it.frag_last)
            return 1'b0;
        ra_flen = 0;
        if (ra_is_first) begin
            if (ra_off < MIN_FIRST_BYTES) begin
                ra_rejected = 1'b1;
                r = make_result(ST_TOO_SHORT, 8'h00);
                return 1'b1;
            end
            ra_fill  = ra_off - HDR_BYTES;
            ra_total = ra_hdr;
            r = make_result(ST_FIRST_OK, 8'h00);
            return 1'b1;
        end
        ra_fill += ra_off;
        r = make_result(ST_APPENDED, 8'h00);
        return 1'b1;
    endfunction

    // ---------------- driver ----------------
    t_in_item  ops_to_send[$];
    t_frag_res predicted_results[$];
    t_in_item  on_bus;
    t_frag_res bus_res;
    bit        nv;
    int        burst_left = 1;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (reassemble_step(on_bus, bus_res))
                    predicted_results.push_back(bus_res);
            end
            // a transaction held by the block keeps its data until accepted
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (ops_to_send.size() > 0) begin
                    on_bus = ops_to_send.pop_front();
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_axis_tvalid <= nv;
                if (nv) begin
                    s_axis_tdata <= {6'b0, on_bus.read_address, on_bus.frag_length,
                                     on_bus.data_byte};
                    s_axis_tuser <= {on_bus.frag_first, on_bus.op};
                    s_axis_tlast <= on_bus.frag_last;
                end
            end
        end
    end

    // ---------------- monitor and receiver ----------------
    t_frag_res seen, want;
    int        mismatches = 0;
    int        n_results = 0;
    int        hold_left = 0;
    int        mode = 0;
    int        mode_left = 0;
    bit        rdy;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.status = m_axis_tuser;
                seen.fill   = m_axis_tdata[14:0];
                seen.total  = m_axis_tdata[46:15];
                seen.rdata  = m_axis_tdata[54:47];
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result status=%0d fill=%0d total=%0h rd=%0h",
                                 $realtime, seen.status, seen.fill, seen.total, seen.rdata);
                end else begin
                    want = predicted_results.pop_front();
                    if (seen.status !== want.status || seen.fill !== want.fill ||
                        seen.total !== want.total || seen.rdata !== want.rdata) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp st=%0d fill=%0d tot=%0h rd=%0h",
                                     $realtime, want.status, want.fill, want.total,
                                     want.rdata);
                            $display("%0t: mismatch got st=%0d fill=%0d tot=%0h rd=%0h",
                                     $realtime, seen.status, seen.fill, seen.total,
                                     seen.rdata);
                        end
                    end
                end
                n_results++;
                // long hold-offs so the block backs up into its input
                if (n_results == 150 || n_results == 700)
                    hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(30, 300);
                end
                mode_left--;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // ---------------- stimulus ----------------
    int ok_addrs[$];  // buffer bytes known to hold data
    int made = 0;

    task automatic push_frag(input logic [7:0] b, input bit f, input bit l,
                             input logic [11:0] n);
        t_in_item it;
        it.op           = OP_FRAG;
        it.data_byte    = b;
        it.frag_first   = f;
        it.frag_last    = l;
        it.frag_length  = n;
        it.read_address = BUF_AW'($urandom);
        ops_to_send.push_back(it);
        made++;
    endtask

    task automatic push_other(input logic [1:0] op, input int a);
        t_in_item it;
        it.op           = op;
        it.data_byte    = 8'($urandom);
        it.frag_first   = 1'($urandom);
        it.frag_last    = 1'($urandom);
        it.frag_length  = 12'($urandom);
        it.read_address = (op == OP_READ) ? BUF_AW'(a) : BUF_AW'($urandom);
        ops_to_send.push_back(it);
        if (op != OP_NONE)
            made++;
    endtask

    // header bytes go out most significant first
    task automatic send_frag(input int len, input int cnt, input logic [31:0] hdr,
                             input bit use_hdr, input bit mark, input bit close);
        logic [7:0] b;
        for (int k = 0; k < cnt; k++) begin
            b = (use_hdr && k < 4) ? hdr[31 - 8*k -: 8] : 8'($urandom);
            push_frag(b, k == 0, close && k == cnt - 1, (k == 0) ? 12'(len) : 12'($urandom));
            if (mark && k >= 4 && k < len) begin
                ok_addrs.push_back(k - 4);
                if ($urandom_range(0, 9) == 0)
                    push_other(OP_READ, k - 4);
            end
        end
    endtask

    function automatic int pick_len(input int lo);
        return ($urandom_range(0, 9) != 0) ? $urandom_range(lo, 24) : $urandom_range(lo, 120);
    endfunction

    task automatic send_shaped(input int lo, input logic [31:0] hdr, input bit use_hdr,
                               input bit mark);
        int len, cnt, r;
        r = $urandom_range(0, 9);
        len = pick_len(lo);
        cnt = len;
        if (r == 0) begin
            cnt = len + $urandom_range(1, 3);           // surplus bytes
        end else if (r == 1) begin
            len = $urandom_range(lo, 4095);             // usually ends well before its length
            cnt = $urandom_range(1, 12);
        end
        send_frag(len, cnt, hdr, use_hdr, mark, 1'b1);
    endtask

    task automatic send_chain();
        int hi;
        bit fresh, good;
        logic [31:0] hdr;
        hi = (ra_limit < BUF_BYTES) ? int'(ra_limit) : BUF_BYTES;
        fresh = ($urandom_range(0, 9) < 7);
        if (fresh)
            push_other(OP_CLEAR, 0);
        good = ($urandom_range(0, 4) != 0);
        if (good)
            hdr = $urandom_range(0, hi);
        else if ($urandom_range(0, 1) != 0)
            hdr = hi + $urandom_range(1, 100);
        else
            hdr = $urandom;
        send_shaped(6, hdr, 1'b1, fresh && good);
        repeat ($urandom_range(0, 3))
            send_shaped(1, '0, 1'b0, 1'b0);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 3))
                   push_frag(8'($urandom), 1'b0, 1'($urandom), 12'($urandom));
            1: push_other(OP_NONE, 0);
            2: begin
                push_other(OP_CLEAR, 0);
                send_frag($urandom_range(0, 5), $urandom_range(1, 3), $urandom, 1'b1,
                          1'b0, 1'b1);
            end
            3: begin
                // open fragment abandoned by the next one
                send_frag(pick_len(1), $urandom_range(1, 4), $urandom, 1'b1, 1'b0, 1'b0);
                send_shaped(1, '0, 1'b0, 1'b0);
            end
            4: begin
                push_frag(8'($urandom), 1'b1, 1'($urandom), 12'd0);
                push_frag(8'($urandom), 1'b0, 1'($urandom), 12'($urandom));
            end
            default: push_other(OP_CLEAR, 0);
        endcase
    endtask

    task automatic random_traffic(input int n);
        int stop, r;
        stop = made + n;
        ok_addrs.delete();
        for (int a = 0; a < BUF_BYTES; a++)
            if (ra_written[a])
                ok_addrs.push_back(a);
        while (made < stop) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_chain();
            end else if (r < 65) begin
                repeat ($urandom_range(1, 4))
                    if (ok_addrs.size() > 0)
                        push_other(OP_READ, ok_addrs[$urandom_range(0, ok_addrs.size() - 1)]);
            end else if (r < 70) begin
                push_other(OP_CLEAR, 0);
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic directed();
        push_frag(8'h3C, 1'b0, 1'b1, 12'd9);            // orphan byte carrying frag_last
        push_other(OP_NONE, 0);
        push_other(OP_CLEAR, 0);
        push_frag(8'h11, 1'b1, 1'b1, 12'd5);            // first fragment shorter than 6
        send_frag(6, 4, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1); // total over the limit
        send_frag(6, 6, 32'd2, 1'b1, 1'b0, 1'b1);        // accepted, fill 2
        send_frag(4095, 2, '0, 1'b0, 1'b0, 1'b1);        // appended, ends early, fill 4
        push_frag(8'h00, 1'b1, 1'b0, 12'd0);            // zero length closes at once
        push_frag(8'hFF, 1'b0, 1'b0, 12'd7);            // so this one is an orphan
        push_frag(8'h5A, 1'b1, 1'b0, 12'd3);            // abandoned by the restart below
        send_frag(1, 2, '0, 1'b0, 1'b0, 1'b1);           // surplus byte dropped, fill 5
        push_other(OP_READ, 0);
        push_other(OP_READ, 4);
        push_other(OP_CLEAR, 0);
    endtask

    task automatic wait_quiet();
        while (ops_to_send.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
            @(posedge i_clk);
        // items without a result may still be in the pipeline
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [23:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ra_limit = v;
        i_cfg_valid <= 1'b0;
    endtask

    logic [23:0] phase_limits[5];

    initial begin
        phase_limits = '{24'd0, 24'hFF_FFFF, 24'd100, 24'($urandom), 24'd16384};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed();
        wait_quiet();
        foreach (phase_limits[p]) begin
            set_limit(phase_limits[p]);
            random_traffic(370);
            wait_quiet();
        end
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_buf_ram.sv
rtl/core/lpfr_ctrl.sv
rtl/core/length_prefixed_fragment_reassembly.sv
rtl/core/lpfr_port_chk.sv
tb/length_prefixed_fragment_reassembly_tb.sv
